// File: hdl/asf_pkg.sv
// Shared types and constants for the anchored spring force pipeline.
package asf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Widths fixed by the Q16.16-style coordinate fields.
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int RAD_W   = 66;
    localparam int ROOT_W  = 33;
    localparam int PARM_W  = 31;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_ANCHOR_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ANCHOR_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ANCHOR_Z    = 3'd2;
    localparam logic [IDX_W-1:0] REG_STIFFNESS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DAMPING     = 3'd4;
    localparam logic [IDX_W-1:0] REG_REST_LENGTH = 3'd5;

    // Per-item context carried alongside the root and divider cells.
    typedef struct packed {
        logic [2:0][DIFF_W-1:0]  w_mag;
        logic [2:0]              w_neg;
        logic [2:0][COORD_W-1:0] vel;
        logic                    on_anchor;
    } ctx_t;

endpackage

// File: hdl/anchored_spring_force.sv
// Top level of the damped anchored spring force pipeline.
//
// Each beat on the input carries one particle's position and velocity and yields
// one force beat: F = -stiffness*(|p - anchor| - rest_length)*u - damping*v, each
// component saturated to 32 bits. The unit accepts one beat per cycle unless the
// two-entry output buffer is full; the whole row advances together and stalls only
// then. It has four front stages (input, difference, squares, sum), a row of 33
// square-root cells (one root bit each), FRAC_BITS + 1 divider cells (one quotient
// bit of all three direction components each), three multiply and clamp stages, and
// the output buffer. With the particle exactly on the anchor the direction follows
// the velocity, or +y when the velocity is zero as well.
module anchored_spring_force #(
    parameter int FRAC_BITS = asf_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [asf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [asf_pkg::DATA_W-1:0] cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic [191:0]               s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // force_x, force_y, force_z, saturated, zero fill
    output logic [103:0]               m_tdata
);
    localparam int CW  = asf_pkg::COORD_W;
    localparam int DW  = asf_pkg::DIFF_W;
    localparam int RW  = asf_pkg::RAD_W;
    localparam int OW  = asf_pkg::ROOT_W;
    localparam int PW  = asf_pkg::PARM_W;
    localparam int NW  = DW + FRAC_BITS;
    localparam int QW  = FRAC_BITS + 1;
    localparam int NDV = FRAC_BITS + 1;
    localparam int SMW = OW + 1;
    localparam int MPW = PW + SMW;
    localparam int MW  = MPW - FRAC_BITS;
    localparam int SPW = MW + QW;
    localparam int SGW = SPW - FRAC_BITS;
    localparam int DPW = PW + CW;
    localparam int DMW = DPW - FRAC_BITS;
    localparam int SW  = SGW + 2;
    localparam int PLW = 3 * CW + 1;
    localparam logic signed [SW-1:0] F_MAX = {{(SW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SW-1:0] F_MIN = {{(SW - 31){1'b1}}, 31'b0};

    // Configuration registers.
    logic [CW-1:0] anchor_reg [3];
    logic [PW-1:0] stiffness_reg, damping_reg, rest_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                anchor_reg[i] <= '0;
            end
            stiffness_reg   <= '0;
            damping_reg     <= '0;
            rest_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                asf_pkg::REG_ANCHOR_X:    anchor_reg[0]   <= cfg_data;
                asf_pkg::REG_ANCHOR_Y:    anchor_reg[1]   <= cfg_data;
                asf_pkg::REG_ANCHOR_Z:    anchor_reg[2]   <= cfg_data;
                asf_pkg::REG_STIFFNESS:   stiffness_reg   <= cfg_data[PW-1:0];
                asf_pkg::REG_DAMPING:     damping_reg     <= cfg_data[PW-1:0];
                asf_pkg::REG_REST_LENGTH: rest_length_reg <= cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic accept;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    // Front stage 0: input register.
    logic                    in_vld_reg;
    logic [2:0][CW-1:0]      pos_reg, vel_reg;

    // Front stage 1: direction operand (offset, or velocity on the anchor).
    logic                    f1_vld_reg;
    asf_pkg::ctx_t           f1_ctx_reg, f1_ctx_next;
    logic [2:0][DW-1:0]      diff;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = DW'($signed({pos_reg[i][CW-1], pos_reg[i]})
                          - $signed({anchor_reg[i][CW-1], anchor_reg[i]}));
        end
        f1_ctx_next.on_anchor = (diff == '0);
        f1_ctx_next.vel       = vel_reg;
        for (int i = 0; i < 3; i++) begin
            logic [DW-1:0] w;
            w = f1_ctx_next.on_anchor ? {vel_reg[i][CW-1], vel_reg[i]} : diff[i];
            f1_ctx_next.w_neg[i] = w[DW-1];
            f1_ctx_next.w_mag[i] = w[DW-1] ? DW'(-w) : w;
        end
    end

    // Front stages 2 and 3: squares, then their sum.
    logic                    f2_vld_reg, f3_vld_reg;
    asf_pkg::ctx_t           f2_ctx_reg, f3_ctx_reg;
    logic [2:0][RW-1:0]      sq_reg;
    logic [RW-1:0]           sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= accept;
            f1_vld_reg <= in_vld_reg;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= s_tdata[CW*i +: CW];
                vel_reg[i] <= s_tdata[CW*(i+3) +: CW];
                sq_reg[i]  <= RW'(f1_ctx_reg.w_mag[i] * f1_ctx_reg.w_mag[i]);
            end
            f1_ctx_reg <= f1_ctx_next;
            f2_ctx_reg <= f1_ctx_reg;
            sum_reg    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            f3_ctx_reg <= f2_ctx_reg;
        end
    end

    // Square-root row, most significant root bit first.
    logic          sq_vld  [OW+1];
    logic [RW-1:0] sq_rem  [OW+1];
    logic [OW-1:0] sq_root [OW+1];
    asf_pkg::ctx_t sq_ctx  [OW+1];

    assign sq_vld[0]  = f3_vld_reg;
    assign sq_rem[0]  = sum_reg;
    assign sq_root[0] = '0;
    assign sq_ctx[0]  = f3_ctx_reg;

    for (genvar k = 0; k < OW; k++) begin : g_sqrt
        asf_sqrt_cell #(.BIT(OW - 1 - k)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_vld(sq_vld[k]), .in_rem(sq_rem[k]), .in_root(sq_root[k]),
            .in_ctx(sq_ctx[k]),
            .out_vld(sq_vld[k+1]), .out_rem(sq_rem[k+1]), .out_root(sq_root[k+1]),
            .out_ctx(sq_ctx[k+1])
        );
    end

    // Divider row: |w_i| * 2^FRAC_BITS / root, one quotient bit per cell.
    logic               dv_vld  [NDV+1];
    logic [2:0][NW-1:0] dv_rem  [NDV+1];
    logic [2:0][QW-1:0] dv_quo  [NDV+1];
    logic [OW-1:0]      dv_root [NDV+1];
    asf_pkg::ctx_t      dv_ctx  [NDV+1];

    assign dv_vld[0]  = sq_vld[OW];
    assign dv_quo[0]  = '0;
    assign dv_root[0] = sq_root[OW];
    assign dv_ctx[0]  = sq_ctx[OW];
    for (genvar i = 0; i < 3; i++) begin : g_num
        assign dv_rem[0][i] = {sq_ctx[OW].w_mag[i], {FRAC_BITS{1'b0}}};
    end

    for (genvar k = 0; k < NDV; k++) begin : g_div
        asf_div_cell #(.NW(NW), .QW(QW), .BIT(FRAC_BITS - k)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_vld(dv_vld[k]), .in_rem(dv_rem[k]), .in_quo(dv_quo[k]),
            .in_root(dv_root[k]), .in_ctx(dv_ctx[k]),
            .out_vld(dv_vld[k+1]), .out_rem(dv_rem[k+1]), .out_quo(dv_quo[k+1]),
            .out_root(dv_root[k+1]), .out_ctx(dv_ctx[k+1])
        );
    end

    // Back stage 1: stretch, direction fixup, first products.
    asf_pkg::ctx_t       dv_out_ctx;
    logic [OW-1:0]       dv_out_root;
    logic [OW-1:0]       dist_len;
    logic signed [OW+1:0] stretch;
    logic [SMW-1:0]      stretch_mag;
    logic [2:0][QW-1:0]  umag_next;
    logic [2:0]          uneg_next;

    assign dv_out_ctx  = dv_ctx[NDV];
    assign dv_out_root = dv_root[NDV];
    assign dist_len    = dv_out_ctx.on_anchor ? '0 : dv_out_root;
    assign stretch     = $signed({2'b00, dist_len})
                         - $signed({{(OW + 2 - PW){1'b0}}, rest_length_reg});
    assign stretch_mag = stretch[OW+1] ? SMW'(-stretch) : SMW'(stretch);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // A zero root means both offset and velocity are zero: point along +y.
            if (dv_out_root == '0) begin
                umag_next[i] = (i == 1) ? (QW'(1) << FRAC_BITS) : '0;
                uneg_next[i] = 1'b0;
            end else begin
                umag_next[i] = dv_quo[NDV][i];
                uneg_next[i] = dv_out_ctx.w_neg[i];
            end
        end
    end

    logic                b1_vld_reg, b2_vld_reg, b3_vld_reg;
    logic [MPW-1:0]      mprod_reg;
    logic                sneg_reg;
    logic [2:0][QW-1:0]  umag_reg;
    logic [2:0]          uneg_reg, vneg_reg, b2_vneg_reg, spneg_reg;
    logic [2:0][DPW-1:0] dprod_reg;
    logic [2:0][SPW-1:0] spprod_reg;
    logic [2:0][DMW-1:0] dmag_reg;
    logic [MW-1:0]       m_mag;
    logic [2:0][CW-1:0]  vmag;

    assign m_mag = mprod_reg[MPW-1:FRAC_BITS];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vmag[i] = dv_out_ctx.vel[i][CW-1] ? CW'(-dv_out_ctx.vel[i]) : dv_out_ctx.vel[i];
        end
    end

    // Back stage 3: combine and clamp.
    logic [PLW-1:0]      res_next, res_reg;
    logic [2:0]          clamp;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [SW-1:0] sp, dm, f;
            sp = SW'(spprod_reg[i][SPW-1:FRAC_BITS]);
            dm = SW'(dmag_reg[i]);
            if (spneg_reg[i]) begin
                sp = -sp;
            end
            if (b2_vneg_reg[i]) begin
                dm = -dm;
            end
            f = sp - dm;
            clamp[i] = 1'b1;
            if (f > F_MAX) begin
                res_next[CW*i +: CW] = F_MAX[CW-1:0];
            end else if (f < F_MIN) begin
                res_next[CW*i +: CW] = F_MIN[CW-1:0];
            end else begin
                res_next[CW*i +: CW] = f[CW-1:0];
                clamp[i] = 1'b0;
            end
        end
        res_next[PLW-1] = |clamp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg <= dv_vld[NDV];
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
        end
        if (en) begin
            mprod_reg <= MPW'(stiffness_reg * stretch_mag);
            sneg_reg  <= stretch[OW+1];
            umag_reg  <= umag_next;
            uneg_reg  <= uneg_next;
            for (int i = 0; i < 3; i++) begin
                dprod_reg[i]  <= DPW'(damping_reg * vmag[i]);
                vneg_reg[i]   <= dv_out_ctx.vel[i][CW-1];
                spprod_reg[i] <= SPW'(m_mag * umag_reg[i]);
                dmag_reg[i]   <= dprod_reg[i][DPW-1:FRAC_BITS];
                spneg_reg[i]  <= (sneg_reg == uneg_reg[i]);
            end
            b2_vneg_reg <= vneg_reg;
            res_reg     <= res_next;
        end
    end

    logic           obuf_rdy;
    logic [PLW-1:0] out_payload;

    assign en = obuf_rdy;

    asf_skid #(.W(PLW)) u_skid (
        .aclk(aclk), .aresetn(aresetn),
        .in_vld(b3_vld_reg && en), .in_rdy(obuf_rdy), .in_data(res_reg),
        .out_vld(m_tvalid), .out_rdy(m_tready), .out_data(out_payload)
    );

    assign m_tdata = {{(104 - PLW){1'b0}}, out_payload};

`ifndef SYNTHESIS
    // The pipeline only stalls while a result sits in the output buffer.
    a_stall_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    // The saturation flag is set only with a component at a clamp limit.
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[96]) |->
            (m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
             m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 ||
             m_tdata[95:64] == 32'h7fffffff || m_tdata[95:64] == 32'h80000000))
        else $error("saturated flag without a clamped component");

    // Stage valids move only with the row enable.
    a_row_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(b3_vld_reg))
        else $error("output stage changed during stall");
`endif
endmodule

// File: hdl/asf_sqrt_cell.sv
// One bit of the integer square root: trial subtract on the residual.
module asf_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [asf_pkg::RAD_W-1:0]     in_rem,
    input  logic [asf_pkg::ROOT_W-1:0]    in_root,
    input  asf_pkg::ctx_t                 in_ctx,
    output logic                          out_vld,
    output logic [asf_pkg::RAD_W-1:0]     out_rem,
    output logic [asf_pkg::ROOT_W-1:0]    out_root,
    output asf_pkg::ctx_t                 out_ctx
);
    localparam int TW = asf_pkg::RAD_W + 1;
    localparam logic [TW-1:0] SQ_BIT = TW'(1) << (2 * BIT);

    logic          vld_reg;
    logic [TW-1:0] trial;
    logic          take;
    logic [asf_pkg::RAD_W-1:0]  rem_next;
    logic [asf_pkg::ROOT_W-1:0] root_next;
    logic [asf_pkg::RAD_W-1:0]  rem_reg;
    logic [asf_pkg::ROOT_W-1:0] root_reg;
    asf_pkg::ctx_t              ctx_reg;

    // With only bits above BIT set in the root, (r + 2^BIT)^2 - r^2 is this trial.
    assign trial = (TW'(in_root) << (BIT + 1)) + SQ_BIT;
    assign take  = {1'b0, in_rem} >= trial;

    always_comb begin
        rem_next  = in_rem;
        root_next = in_root;
        if (take) begin
            rem_next  = asf_pkg::RAD_W'({1'b0, in_rem} - trial);
            root_next = in_root | (asf_pkg::ROOT_W'(1) << BIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            ctx_reg  <= in_ctx;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;
    assign out_ctx  = ctx_reg;
endmodule

// File: hdl/asf_div_cell.sv
// One quotient bit of the three-lane direction divider.
module asf_div_cell #(
    parameter int NW  = 49,
    parameter int QW  = 17,
    parameter int BIT = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [2:0][NW-1:0]            in_rem,
    input  logic [2:0][QW-1:0]            in_quo,
    input  logic [asf_pkg::ROOT_W-1:0]    in_root,
    input  asf_pkg::ctx_t                 in_ctx,
    output logic                          out_vld,
    output logic [2:0][NW-1:0]            out_rem,
    output logic [2:0][QW-1:0]            out_quo,
    output logic [asf_pkg::ROOT_W-1:0]    out_root,
    output asf_pkg::ctx_t                 out_ctx
);
    logic                       vld_reg;
    logic [NW-1:0]              trial;
    logic [2:0][NW-1:0]         rem_next;
    logic [2:0][QW-1:0]         quo_next;
    logic [2:0][NW-1:0]         rem_reg;
    logic [2:0][QW-1:0]         quo_reg;
    logic [asf_pkg::ROOT_W-1:0] root_reg;
    asf_pkg::ctx_t              ctx_reg;

    assign trial = NW'(in_root) << BIT;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rem_next[i] = in_rem[i];
            quo_next[i] = in_quo[i];
            if (in_rem[i] >= trial) begin
                rem_next[i] = in_rem[i] - trial;
                quo_next[i] = in_quo[i] | (QW'(1) << BIT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
        if (en) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            root_reg <= in_root;
            ctx_reg  <= in_ctx;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_quo  = quo_reg;
    assign out_root = root_reg;
    assign out_ctx  = ctx_reg;
endmodule

// File: hdl/asf_skid.sv
// Two-entry output buffer that decouples the pipeline from the result channel.
module asf_skid #(
    parameter int W = 97
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_vld,
    output logic         in_rdy,
    input  logic [W-1:0] in_data,
    output logic         out_vld,
    input  logic         out_rdy,
    output logic [W-1:0] out_data
);
    logic [1:0]   cnt_reg, cnt_next;
    logic [W-1:0] head_reg, tail_reg;
    logic         push, pop;

    assign in_rdy   = (cnt_reg != 2'd2);
    assign out_vld  = (cnt_reg != 2'd0);
    assign out_data = head_reg;
    assign push     = in_vld && in_rdy;
    assign pop      = out_vld && out_rdy;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        if (pop && cnt_reg == 2'd2) begin
            head_reg <= tail_reg;
        end else if (push && (cnt_reg == 2'd0 || pop)) begin
            head_reg <= in_data;
        end
        if (push && cnt_reg == 2'd1 && !pop) begin
            tail_reg <= in_data;
        end
    end
endmodule

// File: sim/anchored_spring_force_tb.sv
// Self-checking testbench for the anchored spring force pipeline.
module anchored_spring_force_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB        = asf_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM  = 1030;
    localparam int CYCLE_CAP = 600000;
    localparam int DRAIN     = FB + 60;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic               sat;
    } force_t;

    class force_scoreboard;
        logic signed [31:0] anc [3];
        logic [30:0] stiff, damp, rest;
        force_t pending [$];
        int errors;
        int checked;
        int sat_seen;

        function new();
            for (int i = 0; i < 3; i++) anc[i] = '0;
            stiff = '0; damp = '0; rest = '0;
            errors = 0; checked = 0; sat_seen = 0;
        endfunction

        function void write_reg(logic [asf_pkg::IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                asf_pkg::REG_ANCHOR_X:    anc[0] = val;
                asf_pkg::REG_ANCHOR_Y:    anc[1] = val;
                asf_pkg::REG_ANCHOR_Z:    anc[2] = val;
                asf_pkg::REG_STIFFNESS:   stiff = val[30:0];
                asf_pkg::REG_DAMPING:     damp = val[30:0];
                asf_pkg::REG_REST_LENGTH: rest = val[30:0];
                default: ;
            endcase
        endfunction

        function logic [127:0] root(logic [127:0] v);
            logic [127:0] r, t;
            r = '0;
            for (int b = 40; b >= 0; b--) begin
                t = r | (128'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function force_t compute(logic [191:0] beat);
            longint d [3], v [3], s, spring, dmp, f;
            logic [127:0] dm [3], vmg [3], um [3], span, vlen, smag, mm, p, q;
            logic un [3];
            logic neg;
            force_t r;
            longint fo [3];
            for (int i = 0; i < 3; i++) begin
                d[i] = longint'($signed(beat[32*i +: 32])) - longint'(anc[i]);
                v[i] = longint'($signed(beat[96 + 32*i +: 32]));
                dm[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
                vmg[i] = v[i] < 0 ? 128'(-v[i]) : 128'(v[i]);
            end
            span = root(dm[0]*dm[0] + dm[1]*dm[1] + dm[2]*dm[2]);
            if (span != 0) begin
                for (int i = 0; i < 3; i++) begin
                    um[i] = (dm[i] << FB) / span;
                    un[i] = d[i] < 0 && um[i] != 0;
                end
            end else begin
                // On the anchor the direction follows the velocity, else +y.
                vlen = root(vmg[0]*vmg[0] + vmg[1]*vmg[1] + vmg[2]*vmg[2]);
                for (int i = 0; i < 3; i++) begin
                    if (vlen != 0) begin
                        um[i] = (vmg[i] << FB) / vlen;
                        un[i] = v[i] < 0 && um[i] != 0;
                    end else begin
                        um[i] = (i == 1) ? (128'd1 << FB) : '0;
                        un[i] = 1'b0;
                    end
                end
            end
            s = longint'(span[63:0]) - longint'(rest);
            smag = s < 0 ? 128'(-s) : 128'(s);
            mm = (128'(stiff) * smag) >> FB;
            r.sat = 1'b0;
            for (int i = 0; i < 3; i++) begin
                p = ((mm * um[i]) >> FB);
                neg = (s < 0) == un[i];
                spring = neg ? -longint'(p[63:0]) : longint'(p[63:0]);
                q = (128'(damp) * vmg[i]) >> FB;
                dmp = v[i] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
                f = spring - dmp;
                if (f > 64'sd2147483647) begin
                    f = 64'sd2147483647; r.sat = 1'b1;
                end
                if (f < -64'sd2147483648) begin
                    f = -64'sd2147483648; r.sat = 1'b1;
                end
                fo[i] = f;
            end
            r.fx = fo[0][31:0]; r.fy = fo[1][31:0]; r.fz = fo[2][31:0];
            return r;
        endfunction

        function void note(logic [191:0] beat);
            pending.push_back(compute(beat));
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check(logic [103:0] beat);
            force_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected output beat %h", beat));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (beat[96]) sat_seen++;
            if (beat[31:0] !== e.fx)
                report($sformatf("force_x %h, expected %h", beat[31:0], e.fx));
            if (beat[63:32] !== e.fy)
                report($sformatf("force_y %h, expected %h", beat[63:32], e.fy));
            if (beat[95:64] !== e.fz)
                report($sformatf("force_z %h, expected %h", beat[95:64], e.fz));
            if (beat[96] !== e.sat)
                report($sformatf("saturated %b, expected %b", beat[96], e.sat));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [asf_pkg::IDX_W-1:0] cfg_index = '0;
    logic [asf_pkg::DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [191:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [103:0] m_tdata;

    force_scoreboard sb = new();
    int cycles = 0;
    int cfg_writes = 0;
    int phases = 0;
    bit sink_free = 1'b0;

    anchored_spring_force #(.FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("anchored_spring_force test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver backpressure, with stretches of no stall at all.
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (sink_free) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                n = $urandom_range(1, 20);
                m_tready <= 1'b1;
                repeat (n) @(posedge aclk);
                n = pick_gap();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    task automatic set_reg(logic [asf_pkg::IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        cfg_writes++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic send_item(logic [191:0] beat, bit no_gap);
        int g;
        g = no_gap ? 0 : pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [191:0] pack(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                          logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        return {vz, vy, vx, pz, py, px};
    endfunction

    task automatic config_phase(int mode);
        logic [31:0] w [6];
        for (int i = 0; i < 6; i++) w[i] = $urandom();
        case (mode)
            0: for (int i = 0; i < 6; i++) w[i] = '0;
            1: begin
                w[0] = 32'h7fffffff; w[1] = 32'h80000000; w[2] = 32'h7fffffff;
                w[3] = 32'hffffffff; w[4] = 32'hffffffff; w[5] = 32'hffffffff;
            end
            2: begin
                // Modest constants keep most forces inside the 32-bit range.
                for (int i = 0; i < 3; i++) w[i] = $urandom_range(0, 32'h00ffffff) - 32'h007fffff;
                w[3] = $urandom_range(0, 32'h0003ffff);
                w[4] = $urandom_range(0, 32'h0000ffff);
                w[5] = $urandom_range(0, 32'h00ffffff);
            end
            default: ;
        endcase
        wait_idle();
        for (int i = 0; i < 6; i++) begin
            set_reg(asf_pkg::IDX_W'(int'(asf_pkg::REG_ANCHOR_X) + i), w[i]);
        end
        // Unused indexes must leave every register alone.
        set_reg(asf_pkg::IDX_W'(int'(asf_pkg::REG_REST_LENGTH) + 1), $urandom());
        set_reg(asf_pkg::IDX_W'(int'(asf_pkg::REG_REST_LENGTH) + 2), $urandom());
        phases++;
    endtask

    function automatic logic [31:0] rand_coord(int kind, logic [31:0] a);
        case (kind)
            0: return $urandom();
            1: return a + $urandom_range(0, 64) - 32;
            2: return a;
            default: return $urandom_range(0, 32'h0007ffff) - 32'h0003ffff;
        endcase
    endfunction

    initial begin
        logic [31:0] p [3], v [3];
        int kind;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, then extremes and the on-anchor cases.
        send_item(pack(0, 0, 0, 0, 0, 0), 1);
        send_item(pack(32'h7fffffff, 32'h80000000, 1, 32'h80000000, 32'h7fffffff, 0), 1);
        end_burst();
        config_phase(1);
        send_item(pack(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0), 0);
        send_item(pack(32'h80000000, 32'h7fffffff, 32'h80000000,
                       32'h7fffffff, 32'h80000000, 32'h7fffffff), 0);
        send_item(pack(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                       32'h80000000, 32'h80000000, 32'h80000000), 0);
        send_item(pack(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 0, 0), 0);
        send_item(pack(0, 0, 0, 32'hffffffff, 1, 32'hffffffff), 0);
        end_burst();
        config_phase(2);
        for (int i = 0; i < 3; i++) p[i] = sb.anc[i];
        send_item(pack(p[0], p[1], p[2], 0, 0, 0), 0);
        send_item(pack(p[0], p[1], p[2], 0, 32'hfff00000, 0), 0);
        send_item(pack(p[0], p[1], p[2], 32'h00010000, 32'h80000000, 32'h7fffffff), 0);
        send_item(pack(p[0] + 1, p[1], p[2], 0, 0, 0), 0);
        send_item(pack(p[0], p[1] - 1, p[2], 0, 0, 0), 0);
        send_item(pack(p[0], p[1], p[2] + 32'h00010000, 5, 0, 0), 0);
        send_item(pack(p[0] + sb.rest, p[1], p[2], 0, 0, 0), 0);
        end_burst();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 150 == 0) begin
                end_burst();
                config_phase(n == 600 ? 0 : (n == 300 ? 1 : ($urandom_range(0, 3) == 0 ? 3 : 2)));
                sink_free = ($urandom_range(0, 2) == 0);
            end
            kind = $urandom_range(0, 9);
            kind = kind < 3 ? 0 : (kind < 5 ? 1 : (kind < 6 ? 2 : 3));
            for (int i = 0; i < 3; i++) begin
                p[i] = rand_coord(kind, sb.anc[i]);
                case ($urandom_range(0, 5))
                    0: v[i] = '0;
                    1: v[i] = $urandom();
                    default: v[i] = $urandom_range(0, 32'h0003ffff) - 32'h0001ffff;
                endcase
            end
            send_item(pack(p[0], p[1], p[2], v[0], v[1], v[2]), sink_free);
        end
        end_burst();
        sink_free = 1'b0;
        wait_idle();

        $display("checked %0d force beats (%0d saturated) over %0d settings, %0d register writes",
                 sb.checked, sb.sat_seen, phases, cfg_writes);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("anchored_spring_force test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("anchored_spring_force test failed");
        end
        $finish;
    end
endmodule
